@@ src/qte_pkg.sv @@
// ----------------------------------------------------------------------------
// qte_pkg
// Shared constants, angle table and helpers for the quaternion to Euler core.
// ----------------------------------------------------------------------------
`default_nettype none

package qte_pkg;

  localparam int QUAT_BITS_DEF     = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_LEN          = 32;
  localparam int ANG_W             = 32;  // 2^32 is a full turn
  localparam int OUT_W             = 16;
  localparam int P_W               = 36;  // one product in Q.30
  localparam int SUM_W             = 38;  // doubled sums of products
  localparam int S_W               = 32;  // clipped arcsine argument
  localparam int CORDIC_W          = 40;
  localparam int RAD_W             = 62;
  localparam int SQRT_STEPS        = 31;
  localparam int SQRT_LAT          = SQRT_STEPS + 1;

  localparam logic signed [S_W-1:0] ONE_Q30 = 32'sh4000_0000;
  localparam logic signed [OUT_W-1:0] HALF_PI = 16'sd16384;

  localparam logic [ANG_W-1:0] ATAN_TAB [ATAN_LEN] = '{
    32'h20000000, 32'h12e4051e, 32'h09fb385b, 32'h051111d4,
    32'h028b0d43, 32'h0145d7e1, 32'h00a2f61e, 32'h00517c55,
    32'h0028be53, 32'h00145f2f, 32'h000a2f98, 32'h000517cc,
    32'h00028be6, 32'h000145f3, 32'h0000a2f9, 32'h0000517c,
    32'h000028be, 32'h0000145f, 32'h00000a2f, 32'h00000517,
    32'h0000028b, 32'h00000145, 32'h000000a2, 32'h00000051,
    32'h00000028, 32'h00000014, 32'h0000000a, 32'h00000005,
    32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
  };

  // top 16 bits of a binary angle, rounded half up, wrapping
  function automatic logic [OUT_W-1:0] angle16(input logic [ANG_W-1:0] a);
    logic [ANG_W-1:0] t;
    t = a + 32'h0000_8000;
    return t[ANG_W-1:ANG_W-OUT_W];
  endfunction

endpackage

`default_nettype wire

@@ src/qte_if.sv @@
// ----------------------------------------------------------------------------
// qte_quat_if / qte_euler_if
// Valid/ready channels for quaternion words in and Euler angle words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface qte_quat_if #(
  parameter int QB = 16
);
  logic                 valid;
  logic                 ready;
  logic signed [QB-1:0] q_w;
  logic signed [QB-1:0] q_x;
  logic signed [QB-1:0] q_y;
  logic signed [QB-1:0] q_z;

  modport source (output valid, q_w, q_x, q_y, q_z, input ready);
  modport sink   (input valid, q_w, q_x, q_y, q_z, output ready);
endinterface

interface qte_euler_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_angle;
  logic signed [15:0] pitch_angle;
  logic signed [15:0] yaw_angle;
  logic               pitch_clipped;

  modport source (output valid, roll_angle, pitch_angle, yaw_angle, pitch_clipped,
                  input ready);
  modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, pitch_clipped,
                  output ready);
endinterface

`default_nettype wire

@@ src/quaternion_to_euler_core.sv @@
// ----------------------------------------------------------------------------
// quaternion_to_euler_core
// Attitude quaternion to ZYX Euler angles (roll, pitch, yaw) as binary angles.
// ----------------------------------------------------------------------------
//  channel  | dir | word
//  ---------+-----+-----------------------------------------------------------
//  quat_i   | in  | q_w, q_x, q_y, q_z (signed, QUAT_BITS each)
//  euler_o  | out | roll_angle, pitch_angle, yaw_angle, pitch_clipped
//
//  One word per cycle while the output is not stalled. The pitch path runs
//  through the product stages, the 31-step square root with its squaring
//  stage and the CORDIC stages.
//  Roll and yaw wait in a 32-deep delay line to line up with pitch.
//  Reset clears valid bits only. A stall at the output freezes every stage.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_to_euler_core #(
  parameter int QUAT_BITS     = qte_pkg::QUAT_BITS_DEF,
  parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  qte_quat_if.sink     quat_i,
  qte_euler_if.source  euler_o
);
  import qte_pkg::*;

  localparam int N_ITER = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
  localparam int DLY    = SQRT_LAT;

  logic en;
  logic out_v_q;

  assign en = !out_v_q || euler_o.ready;
  assign quat_i.ready = en;

  // products and sums
  logic                    pv;
  logic signed [SUM_W-1:0] roll_x, roll_y, yaw_x, yaw_y;
  logic signed [S_W-1:0]   s_val;
  logic                    clip;

  qte_prod #(.QB(QUAT_BITS)) u_prod (
    .clk_i, .rst_ni, .en_i(en), .valid_i(quat_i.valid),
    .w_i(quat_i.q_w), .x_i(quat_i.q_x), .y_i(quat_i.q_y), .z_i(quat_i.q_z),
    .valid_o(pv), .roll_x_o(roll_x), .roll_y_o(roll_y),
    .yaw_x_o(yaw_x), .yaw_y_o(yaw_y), .s_o(s_val), .clip_o(clip)
  );

  // roll and yaw
  logic signed [CORDIC_W-1:0] ry_x [2];
  logic signed [CORDIC_W-1:0] ry_y [2];
  logic [ANG_W-1:0]           ry_ang [2];
  logic                       ry_v, ry_clip;

  assign ry_x[0] = CORDIC_W'(roll_x);
  assign ry_y[0] = CORDIC_W'(roll_y);
  assign ry_x[1] = CORDIC_W'(yaw_x);
  assign ry_y[1] = CORDIC_W'(yaw_y);

  qte_cordic #(.LANES(2), .STAGES(N_ITER)) u_cordic_ry (
    .clk_i, .rst_ni, .en_i(en), .valid_i(pv), .tag_i(clip),
    .x_i(ry_x), .y_i(ry_y), .valid_o(ry_v), .tag_o(ry_clip), .ang_o(ry_ang)
  );

  // pitch
  logic                     sq_v, sq_clip;
  logic [SQRT_STEPS-1:0]    root;
  logic signed [S_W-1:0]    sq_s;

  qte_isqrt u_isqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(pv), .s_i(s_val), .clip_i(clip),
    .valid_o(sq_v), .root_o(root), .s_o(sq_s), .clip_o(sq_clip)
  );

  logic signed [CORDIC_W-1:0] p_x [1];
  logic signed [CORDIC_W-1:0] p_y [1];
  logic [ANG_W-1:0]           p_ang [1];
  logic                       p_v, p_clip;

  assign p_x[0] = $signed(CORDIC_W'(root));
  assign p_y[0] = CORDIC_W'(sq_s);

  qte_cordic #(.LANES(1), .STAGES(N_ITER)) u_cordic_p (
    .clk_i, .rst_ni, .en_i(en), .valid_i(sq_v), .tag_i(sq_clip),
    .x_i(p_x), .y_i(p_y), .valid_o(p_v), .tag_o(p_clip), .ang_o(p_ang)
  );

  // delay line for roll and yaw
  logic             d_v_q    [DLY];
  logic             d_clip_q [DLY];
  logic [OUT_W-1:0] d_roll_q [DLY];
  logic [OUT_W-1:0] d_yaw_q  [DLY];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_v_q[0] <= 1'b0;
    end else if (en) begin
      d_v_q[0] <= ry_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_clip_q[0] <= ry_clip;
      d_roll_q[0] <= angle16(ry_ang[0]);
      d_yaw_q[0]  <= angle16(ry_ang[1]);
    end
  end

  for (genvar k = 1; k < DLY; k++) begin : g_dly
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        d_v_q[k] <= 1'b0;
      end else if (en) begin
        d_v_q[k] <= d_v_q[k-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        d_clip_q[k] <= d_clip_q[k-1];
        d_roll_q[k] <= d_roll_q[k-1];
        d_yaw_q[k]  <= d_yaw_q[k-1];
      end
    end
  end

  // output register: negate, round and saturate pitch
  logic signed [OUT_W-1:0] pitch_r, pitch_d;
  logic signed [OUT_W-1:0] roll_q, pitch_q, yaw_q;
  logic                    clip_q;

  always_comb begin
    pitch_r = $signed(angle16(32'h0 - p_ang[0]));
    pitch_d = pitch_r;
    if (pitch_r > HALF_PI) begin
      pitch_d = HALF_PI;
    end else if (pitch_r < -HALF_PI) begin
      pitch_d = -HALF_PI;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= p_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_q  <= $signed(d_roll_q[DLY-1]);
      yaw_q   <= $signed(d_yaw_q[DLY-1]);
      pitch_q <= pitch_d;
      clip_q  <= p_clip;
    end
  end

  assign euler_o.valid         = out_v_q;
  assign euler_o.roll_angle    = roll_q;
  assign euler_o.pitch_angle   = pitch_q;
  assign euler_o.yaw_angle     = yaw_q;
  assign euler_o.pitch_clipped = clip_q;

  // roll/yaw and pitch paths must stay in step
  a_path_align : assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_v == d_v_q[DLY-1])
    else $error("roll/yaw delay line out of step with pitch path");

  a_clip_agree : assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_v |-> (p_clip == d_clip_q[DLY-1]))
    else $error("clip flag differs between paths");

  a_pitch_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (pitch_q <= HALF_PI && pitch_q >= -HALF_PI))
    else $error("pitch beyond half pi");

endmodule

`default_nettype wire

@@ src/qte_prod.sv @@
// ----------------------------------------------------------------------------
// qte_prod
// Two stages: component products in Q.30, then the vector sums and the
// saturated arcsine argument.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_prod #(
  parameter int QB = 16
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 en_i,
  input  wire                                 valid_i,
  input  wire  signed [QB-1:0]                w_i,
  input  wire  signed [QB-1:0]                x_i,
  input  wire  signed [QB-1:0]                y_i,
  input  wire  signed [QB-1:0]                z_i,
  output logic                                valid_o,
  output logic signed [qte_pkg::SUM_W-1:0]    roll_x_o,
  output logic signed [qte_pkg::SUM_W-1:0]    roll_y_o,
  output logic signed [qte_pkg::SUM_W-1:0]    yaw_x_o,
  output logic signed [qte_pkg::SUM_W-1:0]    yaw_y_o,
  output logic signed [qte_pkg::S_W-1:0]      s_o,
  output logic                                clip_o
);
  import qte_pkg::*;

  localparam int FR   = 2 * (QB - 2);
  localparam int SH_R = (FR >= 30) ? FR - 30 : 0;
  localparam int SH_L = (FR >= 30) ? 0 : 30 - FR;

  function automatic logic signed [P_W-1:0] mul_q30(input logic signed [QB-1:0] a,
                                                    input logic signed [QB-1:0] b);
    logic signed [2*QB-1:0] p;
    logic signed [63:0]     pe;
    p  = a * b;
    pe = 64'(p);
    pe = (pe >>> SH_R) <<< SH_L;
    return pe[P_W-1:0];
  endfunction

  logic                   v1_q, v2_q;
  logic signed [P_W-1:0]  ww_q, xx_q, yy_q, zz_q, yz_q, wx_q, xz_q, wy_q, xy_q, wz_q;
  logic signed [SUM_W-1:0] rx_d, ry_d, yx_d, yy_d, s_full;
  logic signed [SUM_W-1:0] rx_q, ry_q, yx_q, yy2_q;
  logic signed [S_W-1:0]  s_d, s_q;
  logic                   clip_d, clip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ww_q <= mul_q30(w_i, w_i);
      xx_q <= mul_q30(x_i, x_i);
      yy_q <= mul_q30(y_i, y_i);
      zz_q <= mul_q30(z_i, z_i);
      yz_q <= mul_q30(y_i, z_i);
      wx_q <= mul_q30(w_i, x_i);
      xz_q <= mul_q30(x_i, z_i);
      wy_q <= mul_q30(w_i, y_i);
      xy_q <= mul_q30(x_i, y_i);
      wz_q <= mul_q30(w_i, z_i);
    end
  end

  always_comb begin
    ry_d   = (SUM_W'(yz_q) + SUM_W'(wx_q)) <<< 1;
    rx_d   = SUM_W'(ww_q) - SUM_W'(xx_q) - SUM_W'(yy_q) + SUM_W'(zz_q);
    yy_d   = (SUM_W'(xy_q) + SUM_W'(wz_q)) <<< 1;
    yx_d   = SUM_W'(ww_q) + SUM_W'(xx_q) - SUM_W'(yy_q) - SUM_W'(zz_q);
    s_full = (SUM_W'(xz_q) - SUM_W'(wy_q)) <<< 1;
    clip_d = 1'b0;
    s_d    = s_full[S_W-1:0];
    if (s_full > SUM_W'(ONE_Q30)) begin
      s_d    = ONE_Q30;
      clip_d = 1'b1;
    end else if (s_full < -SUM_W'(ONE_Q30)) begin
      s_d    = -ONE_Q30;
      clip_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rx_q   <= rx_d;
      ry_q   <= ry_d;
      yx_q   <= yx_d;
      yy2_q  <= yy_d;
      s_q    <= s_d;
      clip_q <= clip_d;
    end
  end

  assign valid_o  = v2_q;
  assign roll_x_o = rx_q;
  assign roll_y_o = ry_q;
  assign yaw_x_o  = yx_q;
  assign yaw_y_o  = yy2_q;
  assign s_o      = s_q;
  assign clip_o   = clip_q;

endmodule

`default_nettype wire

@@ src/qte_isqrt.sv @@
// ----------------------------------------------------------------------------
// qte_isqrt
// Cosine term of the arcsine: floor(sqrt(2^60 - s^2)), one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_isqrt (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              en_i,
  input  wire                              valid_i,
  input  wire  signed [qte_pkg::S_W-1:0]   s_i,
  input  wire                              clip_i,
  output logic                             valid_o,
  output logic [qte_pkg::SQRT_STEPS-1:0]   root_o,
  output logic signed [qte_pkg::S_W-1:0]   s_o,
  output logic                             clip_o
);
  import qte_pkg::*;

  logic                   v_q    [SQRT_STEPS+1];
  logic [RAD_W-1:0]       n_q    [SQRT_STEPS+1];
  logic [RAD_W-1:0]       res_q  [SQRT_STEPS+1];
  logic signed [S_W-1:0]  s_q    [SQRT_STEPS+1];
  logic                   clip_q [SQRT_STEPS+1];
  logic signed [RAD_W-1:0] sq;

  // |s| <= 2^30, so the square fits the radicand width
  assign sq = s_i * s_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q[0]    <= (RAD_W'(1) << 60) - sq;
      res_q[0]  <= '0;
      s_q[0]    <= s_i;
      clip_q[0] <= clip_i;
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [RAD_W-1:0] BITV = RAD_W'(1) << (2 * (SQRT_STEPS - 1 - k));
    logic [RAD_W-1:0] trial;
    logic             ge;

    assign trial = res_q[k] + BITV;
    assign ge    = (n_q[k] >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[k+1]    <= ge ? n_q[k] - trial : n_q[k];
        res_q[k+1]  <= ge ? (res_q[k] >> 1) + BITV : res_q[k] >> 1;
        s_q[k+1]    <= s_q[k];
        clip_q[k+1] <= clip_q[k];
      end
    end
  end

  assign valid_o = v_q[SQRT_STEPS];
  assign root_o  = res_q[SQRT_STEPS][SQRT_STEPS-1:0];
  assign s_o     = s_q[SQRT_STEPS];
  assign clip_o  = clip_q[SQRT_STEPS];

endmodule

`default_nettype wire

@@ src/qte_cordic.sv @@
// ----------------------------------------------------------------------------
// qte_cordic
// Vectoring CORDIC, one rotation per stage, LANES vectors side by side.
// Gives atan2(y, x) as a 32-bit binary angle.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_cordic #(
  parameter int LANES  = 1,
  parameter int STAGES = 16
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 en_i,
  input  wire                                 valid_i,
  input  wire                                 tag_i,
  input  wire  signed [qte_pkg::CORDIC_W-1:0] x_i [LANES],
  input  wire  signed [qte_pkg::CORDIC_W-1:0] y_i [LANES],
  output logic                                valid_o,
  output logic                                tag_o,
  output logic [qte_pkg::ANG_W-1:0]           ang_o [LANES]
);
  import qte_pkg::*;

  logic v_q   [STAGES+1];
  logic tag_q [STAGES+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q[0] <= tag_i;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_ctl
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= v_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tag_q[i+1] <= tag_q[i];
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic signed [CORDIC_W-1:0] x_q [STAGES+1];
    logic signed [CORDIC_W-1:0] y_q [STAGES+1];
    logic [ANG_W-1:0]           a_q [STAGES+1];
    logic                       z_q [STAGES+1];
    logic signed [CORDIC_W-1:0] x0_d, y0_d;
    logic [ANG_W-1:0]           a0_d;

    // fold the left half plane into the right one
    always_comb begin
      x0_d = x_i[l];
      y0_d = y_i[l];
      a0_d = '0;
      if (x_i[l] < 0) begin
        if (y_i[l] >= 0) begin
          x0_d = y_i[l];
          y0_d = -x_i[l];
          a0_d = 32'h4000_0000;
        end else begin
          x0_d = -y_i[l];
          y0_d = x_i[l];
          a0_d = 32'hC000_0000;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[0] <= x0_d;
        y_q[0] <= y0_d;
        a_q[0] <= a0_d;
        z_q[0] <= (x_i[l] == 0) && (y_i[l] == 0);
      end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_rot
      logic signed [CORDIC_W-1:0] xs, ys;
      assign xs = x_q[i] >>> i;
      assign ys = y_q[i] >>> i;

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (!y_q[i][CORDIC_W-1]) begin
            x_q[i+1] <= x_q[i] + ys;
            y_q[i+1] <= y_q[i] - xs;
            a_q[i+1] <= a_q[i] + ATAN_TAB[i];
          end else begin
            x_q[i+1] <= x_q[i] - ys;
            y_q[i+1] <= y_q[i] + xs;
            a_q[i+1] <= a_q[i] - ATAN_TAB[i];
          end
          z_q[i+1] <= z_q[i];
        end
      end
    end

    assign ang_o[l] = z_q[STAGES] ? '0 : a_q[STAGES];
  end

  assign valid_o = v_q[STAGES];
  assign tag_o   = tag_q[STAGES];

endmodule

`default_nettype wire

@@ tb/sv/qte_checker.sv @@
// ----------------------------------------------------------------------------
// qte_checker
// Watches the quaternion and Euler channels of the core, computes the expected
// roll, pitch and yaw for every accepted quaternion word and compares each
// Euler word against the oldest pending prediction.
// ----------------------------------------------------------------------------
module qte_checker (
  input  wire         clk_i,
  input  wire         rst_ni,
  qte_quat_if         quat,
  qte_euler_if        euler,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o,
  output int unsigned quat_cnt_o,
  output int unsigned euler_cnt_o,
  output int unsigned clip_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSTAGE = (qte_pkg::CORDIC_STAGES_DEF > qte_pkg::ATAN_LEN) ?
                          qte_pkg::ATAN_LEN : qte_pkg::CORDIC_STAGES_DEF;
  localparam longint ONE = longint'(1) << 30;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic               clipped;
  } euler_t;

  euler_t euler_q[$];

  // product of two Q2.14 components, scaled to Q.30
  function automatic longint prod30(logic signed [15:0] a, logic signed [15:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return p <<< 2;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // four-quadrant arctangent, 2^32 per turn
  function automatic logic [31:0] atan2_bin(longint x, longint y);
    logic [31:0] a;
    longint t, xs, ys;
    a = '0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; a = 32'h4000_0000;
      end else begin
        x = -y; y = t; a = 32'hC000_0000;
      end
    end
    for (int i = 0; i < NSTAGE; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; a += qte_pkg::ATAN_TAB[i];
      end else begin
        x -= ys; y += xs; a -= qte_pkg::ATAN_TAB[i];
      end
    end
    return a;
  endfunction

  function automatic logic [15:0] round_top(logic [31:0] a);
    logic [31:0] t;
    t = a + 32'h0000_8000;
    return t[31:16];
  endfunction

  function automatic euler_t predict_euler(logic signed [15:0] w, logic signed [15:0] x,
                                           logic signed [15:0] y, logic signed [15:0] z);
    euler_t e;
    longint ww, xx, yy, zz, s, c;
    int p;
    ww = prod30(w, w); xx = prod30(x, x); yy = prod30(y, y); zz = prod30(z, z);
    s = 2 * (prod30(x, z) - prod30(w, y));
    e.clipped = 1'b0;
    if (s > ONE) begin
      s = ONE; e.clipped = 1'b1;
    end
    if (s < -ONE) begin
      s = -ONE; e.clipped = 1'b1;
    end
    c = longint'(root_floor(longint'(ONE * ONE - s * s)));
    p = int'(signed'(round_top(32'h0 - atan2_bin(c, s))));
    if (p > 16384) p = 16384;
    if (p < -16384) p = -16384;
    e.pitch = 16'(p);
    e.roll = round_top(atan2_bin(ww - xx - yy + zz, 2 * (prod30(y, z) + prod30(w, x))));
    e.yaw = round_top(atan2_bin(ww + xx - yy - zz, 2 * (prod30(x, y) + prod30(w, z))));
    return e;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    euler_t want;
    if (!rst_ni) begin
      euler_q.delete();
      fail_cnt_o <= 0;
      quat_cnt_o <= 0;
      euler_cnt_o <= 0;
      clip_cnt_o <= 0;
    end else begin
      if (quat.valid && quat.ready) begin
        want = predict_euler(quat.q_w, quat.q_x, quat.q_y, quat.q_z);
        euler_q.push_back(want);
        quat_cnt_o <= quat_cnt_o + 1;
        if (want.clipped) clip_cnt_o <= clip_cnt_o + 1;
      end
      if (euler.valid && euler.ready) begin
        euler_cnt_o <= euler_cnt_o + 1;
        if (euler_q.size() == 0) begin
          $error("euler word with no quaternion pending");
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          want = euler_q.pop_front();
          if (euler.roll_angle !== want.roll ||
              euler.pitch_angle !== want.pitch ||
              euler.yaw_angle !== want.yaw ||
              euler.pitch_clipped !== want.clipped)
            fail_cnt_o <= fail_cnt_o + 1;
          if (euler.roll_angle !== want.roll)
            $error("roll_angle: expected %0d, got %0d", want.roll, euler.roll_angle);
          if (euler.pitch_angle !== want.pitch)
            $error("pitch_angle: expected %0d, got %0d", want.pitch, euler.pitch_angle);
          if (euler.yaw_angle !== want.yaw)
            $error("yaw_angle: expected %0d, got %0d", want.yaw, euler.yaw_angle);
          if (euler.pitch_clipped !== want.clipped)
            $error("pitch_clipped: expected %0b, got %0b", want.clipped,
                   euler.pitch_clipped);
        end
      end
    end
  end

  assign pending_o = euler_q.size();

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Drives quaternion words into the core through directed corner cases and
// random traffic under several idle/stall phases, then reports the verdict
// from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG = 20000;
  localparam int DRAIN    = 80;

  logic clk_i;
  logic rst_ni;
  int   idle_pct;
  int   stall_pct;
  int   quiet_cycles;
  int unsigned fail_cnt, pending, quat_cnt, euler_cnt, clip_cnt;

  qte_quat_if #(.QB(16)) quat_if ();
  qte_euler_if           euler_if ();

  quaternion_to_euler_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .quat_i  (quat_if),
    .euler_o (euler_if)
  );

  qte_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .quat        (quat_if),
    .euler       (euler_if),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending),
    .quat_cnt_o  (quat_cnt),
    .euler_cnt_o (euler_cnt),
    .clip_cnt_o  (clip_cnt)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    quat_if.valid = 1'b0;
    quat_if.q_w = '0;
    quat_if.q_x = '0;
    quat_if.q_y = '0;
    quat_if.q_z = '0;
    euler_if.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    euler_if.ready <= rst_ni && ($urandom_range(0, 99) >= stall_pct);
  end

  // end the run if nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (quat_if.valid && quat_if.ready) || (euler_if.valid && euler_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("timeout: no word moved for %0d cycles", WATCHDOG);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y, logic [15:0] z);
    while ($urandom_range(0, 99) < idle_pct) begin
      quat_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    quat_if.valid <= 1'b1;
    quat_if.q_w <= w;
    quat_if.q_x <= x;
    quat_if.q_y <= y;
    quat_if.q_z <= z;
    do @(posedge clk_i); while (!quat_if.ready);
  endtask

  // random component: mostly within the unit range, sometimes any code
  function automatic logic [15:0] rand_comp();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  initial begin
    idle_pct = 0;
    stall_pct = 0;
    quiet_cycles = 0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero, identity, axis turns, full-scale codes
    send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_quat(16'sd16384, 16'sd0, 16'sd0, 16'sd0);
    send_quat(16'sd0, 16'sd16384, 16'sd0, 16'sd0);   // roll at plus pi wraps
    send_quat(16'sd0, 16'sd0, 16'sd16384, 16'sd0);
    send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd16384);   // yaw at plus pi wraps
    send_quat(16'sd11585, 16'sd11585, 16'sd0, 16'sd0);
    send_quat(16'sd11585, 16'sd0, 16'sd0, -16'sd11585);
    send_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_quat(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_quat(16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF);
    send_quat(16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001);
    // arcsine argument exactly at one, and past it
    send_quat(16'sd16384, 16'sd0, -16'sd8192, 16'sd0);
    send_quat(16'sd16384, 16'sd0, 16'sd8192, 16'sd0);
    send_quat(16'sd16384, 16'sd0, -16'sd16384, 16'sd0);
    send_quat(16'sd0, 16'sd16384, 16'sd0, 16'sd16384);
    send_quat(16'sd11585, 16'sd0, -16'sd11586, 16'sd0);
    send_quat(16'sd11585, 16'sd0, 16'sd11586, 16'sd0);
    send_quat(16'sd8192, 16'sd8192, -16'sd8192, 16'sd8192);
    send_quat(16'sd8192, -16'sd8192, 16'sd8192, 16'sd8192);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 76; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 76; end
        default: begin idle_pct = 11; stall_pct = 11; end
      endcase
      for (int n = 0; n < 270; n++) begin
        send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
        // hold off until the pipe has drained once
        if (ph == 2 && n == 100) begin
          quat_if.valid <= 1'b0;
          while (pending != 0) @(posedge clk_i);
        end
      end
    end
    quat_if.valid <= 1'b0;
    idle_pct = 0;
    stall_pct = 0;

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    $display("sent %0d quaternion words, checked %0d euler words, %0d with pitch clipped",
             quat_cnt, euler_cnt, clip_cnt);
    $display("covered corner codes, gimbal lock, wrap at pi and four idle/stall phases");
    if (fail_cnt == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ files.f @@
src/qte_pkg.sv
src/qte_if.sv
src/qte_prod.sv
src/qte_isqrt.sv
src/qte_cordic.sv
src/quaternion_to_euler_core.sv
tb/sv/qte_checker.sv
tb/sv/tb.sv
